// ===== design/btp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btp_pkg: shared types and constants for barometric compensation
// Payload structs, configuration register indexes and fixed coefficients.
// ----------------------------------------------------------------------------
package btp_pkg;

  typedef struct packed {
    logic [23:0] raw_temp;
    logic [23:0] raw_press;
  } sample_t;

  typedef struct packed {
    logic signed [23:0] temp_q16;
    logic [23:0]        press_q6;
    logic               press_clamped;
  } result_t;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 48;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_A    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_B    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_C    = 4'd3;

  // Fractional bits of every floored polynomial term
  localparam int ACC_FRAC = 24;
  // Bias removed from P1 and P2
  localparam logic signed [17:0] P_OFFSET = 18'sd16384;

endpackage
`default_nettype wire

// ===== design/btp_dly.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btp_dly: fixed-length register delay line
// Aligns operands and partial terms between pipeline stages.
// ----------------------------------------------------------------------------
module btp_dly #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [N];

  always_ff @(posedge clk) begin
    line[0] <= d;
    for (int i = 1; i < N; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign q = line[N-1];

endmodule
`default_nettype wire

// ===== design/btp_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btp_mul: two-stage signed multiplier
// Splits the wide operand into 32-bit slices, registers the slice products,
// then registers their weighted sum.
// ----------------------------------------------------------------------------
module btp_mul #(
  parameter int AW = 32,
  parameter int BW = 24
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int PW  = AW + BW;
  localparam int NCH = (AW + 31) / 32;
  localparam int TW  = AW - 32 * (NCH - 1);

  logic signed [PW-1:0] pp [NCH];
  logic signed [PW-1:0] sum;

  for (genvar k = 0; k < NCH; k++) begin : g_chunk
    if (k == NCH - 1) begin : g_top
      logic signed [TW-1:0]    ca;
      logic signed [TW+BW-1:0] prod;
      assign ca   = a[AW-1 -: TW];
      assign prod = ca * b;
      always_ff @(posedge clk) begin
        pp[k] <= PW'(prod);
      end
    end else begin : g_low
      logic signed [32:0]      ca;
      logic signed [33+BW-1:0] prod;
      assign ca   = {1'b0, a[32*k +: 32]};
      assign prod = ca * b;
      always_ff @(posedge clk) begin
        pp[k] <= PW'(prod);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < NCH; k++) begin
      sum = sum + (pp[k] <<< (32 * k));
    end
  end

  always_ff @(posedge clk) begin
    p <= sum;
  end

endmodule
`default_nettype wire

// ===== design/baro_temp_press_compensation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// baro_temp_press_compensation: temperature and pressure linearization
// Quadratic temperature, then cubic pressure polynomial in exact fixed point.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle outside reset; the multiplier chain is fully pipelined
// and every multiply takes two register stages.
// Reset clears the calibration registers and all pipeline valid bits.
// Results are not back-pressured: done pulses once per sample.
module baro_temp_press_compensation #(
  parameter int FRAC_BITS_TEMP  = 16,
  parameter int FRAC_BITS_PRESS = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  btp_pkg::sample_t                    sample,
  output logic                                done,
  output btp_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [btp_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [btp_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int F      = FRAC_BITS_TEMP;
  localparam int XW     = 62;
  localparam int TSH    = 48 - F;
  localparam int PSH    = btp_pkg::ACC_FRAC - FRAC_BITS_PRESS;
  localparam int ACC_W  = ((88 - 3 * F) > 48 ? (88 - 3 * F) : 48) + 4;
  localparam int NVLD   = 15;

  localparam logic signed [XW-1:0]    TRND  = XW'(1) <<< (TSH - 1);
  localparam logic signed [XW-1:0]    T_MAX = (XW'(1) <<< 23) - XW'(1);
  localparam logic signed [XW-1:0]    T_MIN = -(XW'(1) <<< 23);
  localparam logic signed [ACC_W-1:0] PRND  = ACC_W'(1) <<< (PSH - 1);
  localparam logic signed [ACC_W-1:0] P_MAX = (ACC_W'(1) <<< 24) - ACC_W'(1);

  // floor-align an exact product to the accumulator's fractional point
  function automatic logic signed [ACC_W-1:0] align(input logic signed [127:0] x,
                                                    input int sh);
    logic signed [127:0] y;
    if (sh >= 0) begin
      y = x <<< sh;
    end else begin
      y = x >>> (-sh);
    end
    return ACC_W'(y);
  endfunction

  // Calibration registers
  logic [39:0] temp_calib;
  logic [47:0] press_calib_a;
  logic [47:0] press_calib_b;
  logic [31:0] press_calib_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      press_calib_c <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        btp_pkg::REG_TEMP_CALIB: temp_calib    <= cfg_wdata[39:0];
        btp_pkg::REG_PRESS_A:    press_calib_a <= cfg_wdata;
        btp_pkg::REG_PRESS_B:    press_calib_b <= cfg_wdata;
        btp_pkg::REG_PRESS_C:    press_calib_c <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1;
  logic signed [16:0] t2s;
  logic signed [7:0]  t3;
  logic signed [17:0] p1m;
  logic signed [17:0] p2m;
  logic signed [7:0]  p3, p4, p7, p8, p10, p11;
  logic [15:0]        p5;
  logic signed [16:0] p6s;
  logic signed [15:0] p9;

  assign t1  = temp_calib[39:24];
  assign t2s = {1'b0, temp_calib[23:8]};
  assign t3  = temp_calib[7:0];
  assign p1m = 18'($signed(press_calib_a[47:32])) - btp_pkg::P_OFFSET;
  assign p2m = 18'($signed(press_calib_a[31:16])) - btp_pkg::P_OFFSET;
  assign p3  = press_calib_a[15:8];
  assign p4  = press_calib_a[7:0];
  assign p5  = press_calib_b[47:32];
  assign p6s = {1'b0, press_calib_b[31:16]};
  assign p7  = press_calib_b[15:8];
  assign p8  = press_calib_b[7:0];
  assign p9  = press_calib_c[31:16];
  assign p10 = press_calib_c[15:8];
  assign p11 = press_calib_c[7:0];

  // Handshake and valid tracking
  logic            accept;
  logic [NVLD-1:0] vld;

  assign busy   = rst;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[NVLD-2:0], accept};
      done <= vld[NVLD-1];
    end
  end

  // Stage 1: offset temperature, widen pressure
  logic signed [24:0] d_l1;
  logic signed [24:0] u_l1;

  always_ff @(posedge clk) begin
    d_l1 <= $signed({1'b0, sample.raw_temp}) - $signed({1'b0, t1, 8'h00});
    u_l1 <= $signed({1'b0, sample.raw_press});
  end

  // Temperature path
  logic signed [41:0] dt2_l3, dt2_l5;
  logic signed [49:0] dd_l3;
  logic signed [57:0] ddt3_l5;
  logic signed [XW-1:0] x_l6, x_next, xs;
  logic signed [23:0] t_l7, t_next, t_l9, t_l11, t_l15;

  btp_mul #(.AW(25), .BW(17)) u_m_dt2  (.clk(clk), .a(d_l1),  .b(t2s),  .p(dt2_l3));
  btp_mul #(.AW(25), .BW(25)) u_m_dd   (.clk(clk), .a(d_l1),  .b(d_l1), .p(dd_l3));
  btp_mul #(.AW(50), .BW(8))  u_m_ddt3 (.clk(clk), .a(dd_l3), .b(t3),   .p(ddt3_l5));
  btp_dly #(.W(42), .N(2))    u_d_dt2  (.clk(clk), .d(dt2_l3), .q(dt2_l5));

  always_comb begin
    x_next = (XW'(dt2_l5) <<< 18) + XW'(ddt3_l5) + TRND;
    xs     = x_l6 >>> TSH;
    if (xs > T_MAX) begin
      t_next = 24'(T_MAX);
    end else if (xs < T_MIN) begin
      t_next = 24'(T_MIN);
    end else begin
      t_next = 24'(xs);
    end
  end

  always_ff @(posedge clk) begin
    x_l6 <= x_next;
    t_l7 <= t_next;
  end

  // Pressure-only products
  logic signed [24:0] u_l3;
  logic signed [49:0] u2_l3;
  logic signed [42:0] p1u_l3, p2u_l3, p2u_l7;
  logic signed [32:0] p3u_l3, p4u_l3, p3u_l7, p4u_l7;
  logic signed [74:0] u3_l5;
  logic signed [65:0] p9u2_l5;
  logic signed [57:0] p10u2_l5, p10u2_l7;
  logic signed [82:0] p11u3_l7;

  btp_dly #(.W(25), .N(2))    u_d_u    (.clk(clk), .d(u_l1), .q(u_l3));
  btp_mul #(.AW(25), .BW(25)) u_m_uu   (.clk(clk), .a(u_l1), .b(u_l1), .p(u2_l3));
  btp_mul #(.AW(25), .BW(18)) u_m_p1u  (.clk(clk), .a(u_l1), .b(p1m),  .p(p1u_l3));
  btp_mul #(.AW(25), .BW(18)) u_m_p2u  (.clk(clk), .a(u_l1), .b(p2m),  .p(p2u_l3));
  btp_mul #(.AW(25), .BW(8))  u_m_p3u  (.clk(clk), .a(u_l1), .b(p3),   .p(p3u_l3));
  btp_mul #(.AW(25), .BW(8))  u_m_p4u  (.clk(clk), .a(u_l1), .b(p4),   .p(p4u_l3));
  btp_mul #(.AW(50), .BW(25)) u_m_u3   (.clk(clk), .a(u2_l3), .b(u_l3), .p(u3_l5));
  btp_mul #(.AW(50), .BW(16)) u_m_p9   (.clk(clk), .a(u2_l3), .b(p9),   .p(p9u2_l5));
  btp_mul #(.AW(50), .BW(8))  u_m_p10  (.clk(clk), .a(u2_l3), .b(p10),  .p(p10u2_l5));
  btp_mul #(.AW(75), .BW(8))  u_m_p11  (.clk(clk), .a(u3_l5), .b(p11),  .p(p11u3_l7));

  btp_dly #(.W(43), .N(4)) u_d_p2u   (.clk(clk), .d(p2u_l3),   .q(p2u_l7));
  btp_dly #(.W(33), .N(4)) u_d_p3u   (.clk(clk), .d(p3u_l3),   .q(p3u_l7));
  btp_dly #(.W(33), .N(4)) u_d_p4u   (.clk(clk), .d(p4u_l3),   .q(p4u_l7));
  btp_dly #(.W(58), .N(2)) u_d_p10u2 (.clk(clk), .d(p10u2_l5), .q(p10u2_l7));

  // Temperature-dependent products
  logic signed [47:0]  t2_l9;
  logic signed [40:0]  p6t_l9;
  logic signed [66:0]  p2ut_l9;
  logic signed [56:0]  p3ut_l9, p4ut_l9;
  logic signed [81:0]  p10u2t_l9;
  logic signed [71:0]  t3_l11;
  logic signed [55:0]  p7t2_l11;
  logic signed [80:0]  p3ut2_l11, p4ut2_l11;
  logic signed [79:0]  p8t3_l13;
  logic signed [104:0] p4ut3_l13;

  btp_dly #(.W(24), .N(2)) u_d_t9  (.clk(clk), .d(t_l7), .q(t_l9));
  btp_dly #(.W(24), .N(2)) u_d_t11 (.clk(clk), .d(t_l9), .q(t_l11));
  btp_dly #(.W(24), .N(8)) u_d_t15 (.clk(clk), .d(t_l7), .q(t_l15));

  btp_mul #(.AW(24), .BW(24)) u_m_tt    (.clk(clk), .a(t_l7),     .b(t_l7), .p(t2_l9));
  btp_mul #(.AW(24), .BW(17)) u_m_p6t   (.clk(clk), .a(t_l7),     .b(p6s),  .p(p6t_l9));
  btp_mul #(.AW(43), .BW(24)) u_m_p2ut  (.clk(clk), .a(p2u_l7),   .b(t_l7), .p(p2ut_l9));
  btp_mul #(.AW(33), .BW(24)) u_m_p3ut  (.clk(clk), .a(p3u_l7),   .b(t_l7), .p(p3ut_l9));
  btp_mul #(.AW(33), .BW(24)) u_m_p4ut  (.clk(clk), .a(p4u_l7),   .b(t_l7), .p(p4ut_l9));
  btp_mul #(.AW(58), .BW(24)) u_m_p10t  (.clk(clk), .a(p10u2_l7), .b(t_l7), .p(p10u2t_l9));
  btp_mul #(.AW(48), .BW(24)) u_m_t3    (.clk(clk), .a(t2_l9),    .b(t_l9), .p(t3_l11));
  btp_mul #(.AW(48), .BW(8))  u_m_p7t2  (.clk(clk), .a(t2_l9),    .b(p7),   .p(p7t2_l11));
  btp_mul #(.AW(57), .BW(24)) u_m_p3ut2 (.clk(clk), .a(p3ut_l9),  .b(t_l9), .p(p3ut2_l11));
  btp_mul #(.AW(57), .BW(24)) u_m_p4ut2 (.clk(clk), .a(p4ut_l9),  .b(t_l9), .p(p4ut2_l11));
  btp_mul #(.AW(72), .BW(8))  u_m_p8t3  (.clk(clk), .a(t3_l11),   .b(p8),   .p(p8t3_l13));
  btp_mul #(.AW(81), .BW(24)) u_m_p4ut3 (.clk(clk), .a(p4ut2_l11), .b(t_l11), .p(p4ut3_l13));

  // Floor every term to 24 fractional bits and line them up at stage 13
  logic signed [ACC_W-1:0] a1, a2, a3, a4, a5, a6, a7, a8, a9, a10, a11;
  logic signed [ACC_W-1:0] a2_d, a3_d, a5_d, a6_d, a7_d, a9_d, a10_d, a11_d;

  assign a1  = align(128'($signed({1'b0, p5})), 27);
  assign a2  = align(128'(p6t_l9), 18 - F);
  assign a3  = align(128'(p7t2_l11), 16 - 2 * F);
  assign a4  = align(128'(p8t3_l13), 9 - 3 * F);
  assign a5  = align(128'(p1u_l3), 4);
  assign a6  = align(128'(p2ut_l9), -5 - F);
  assign a7  = align(128'(p3ut2_l11), -8 - 2 * F);
  assign a8  = align(128'(p4ut3_l13), -13 - 3 * F);
  assign a9  = align(128'(p9u2_l5), -24);
  assign a10 = align(128'(p10u2t_l9), -24 - F);
  assign a11 = align(128'(p11u3_l7), -41);

  btp_dly #(.W(ACC_W), .N(4))  u_d_a2  (.clk(clk), .d(a2),  .q(a2_d));
  btp_dly #(.W(ACC_W), .N(2))  u_d_a3  (.clk(clk), .d(a3),  .q(a3_d));
  btp_dly #(.W(ACC_W), .N(10)) u_d_a5  (.clk(clk), .d(a5),  .q(a5_d));
  btp_dly #(.W(ACC_W), .N(4))  u_d_a6  (.clk(clk), .d(a6),  .q(a6_d));
  btp_dly #(.W(ACC_W), .N(2))  u_d_a7  (.clk(clk), .d(a7),  .q(a7_d));
  btp_dly #(.W(ACC_W), .N(8))  u_d_a9  (.clk(clk), .d(a9),  .q(a9_d));
  btp_dly #(.W(ACC_W), .N(4))  u_d_a10 (.clk(clk), .d(a10), .q(a10_d));
  btp_dly #(.W(ACC_W), .N(6))  u_d_a11 (.clk(clk), .d(a11), .q(a11_d));

  // Accumulate, round, saturate
  logic signed [ACC_W-1:0] sa_l14, sb_l14, sc_l14, s_l15, ps;
  logic [23:0]             pq_next;
  logic                    clamp_next;

  always_ff @(posedge clk) begin
    sa_l14 <= a1 + a2_d + a3_d + a4;
    sb_l14 <= a5_d + a6_d + a7_d + a8;
    sc_l14 <= a9_d + a10_d + a11_d + PRND;
    s_l15  <= sa_l14 + sb_l14 + sc_l14;
  end

  always_comb begin
    ps = s_l15 >>> PSH;
    if (ps < 0) begin
      pq_next    = '0;
      clamp_next = 1'b1;
    end else if (ps > P_MAX) begin
      pq_next    = '1;
      clamp_next = 1'b1;
    end else begin
      pq_next    = ps[23:0];
      clamp_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    result.temp_q16      <= t_l15;
    result.press_q6      <= pq_next;
    result.press_clamped <= clamp_next;
  end

endmodule
`default_nettype wire

// ===== tb/tb_baro_temp_press_compensation.sv =====
// ----------------------------------------------------------------------------
// tb_baro_temp_press_compensation: self-checking bench for the compensation
// Streams raw sample pairs under several calibration sets and compares every
// result with an exact 128-bit fixed-point prediction of the polynomials.
// ----------------------------------------------------------------------------
module tb_baro_temp_press_compensation;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  class comp_scoreboard;
    logic [39:0]      temp_calib;
    logic [47:0]      press_a;
    logic [47:0]      press_b;
    logic [31:0]      press_c;
    btp_pkg::result_t pending[$];
    int               errors;

    function new();
      temp_calib = '0;
      press_a    = '0;
      press_b    = '0;
      press_c    = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [btp_pkg::CFG_IDX_W-1:0] idx,
                            logic [btp_pkg::CFG_W-1:0] data);
      case (idx)
        btp_pkg::REG_TEMP_CALIB: temp_calib = data[39:0];
        btp_pkg::REG_PRESS_A:    press_a    = data;
        btp_pkg::REG_PRESS_B:    press_b    = data;
        btp_pkg::REG_PRESS_C:    press_c    = data[31:0];
        default: ;
      endcase
    endfunction

    // coef * u^a * t^b scaled to 24 fractional bits, floored
    function wide_t poly_term(wide_t coef, wide_t u, int a, wide_t t, int b, int e);
      wide_t x;
      int    sh;
      x = coef;
      for (int i = 0; i < a; i++) x = x * u;
      for (int i = 0; i < b; i++) x = x * t;
      sh = btp_pkg::ACC_FRAC - e - b * 16;
      return (sh >= 0) ? (x <<< sh) : (x >>> (-sh));
    endfunction

    function void note_sample(btp_pkg::sample_t s);
      logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
      logic signed [15:0] p1, p2, p9;
      wide_t   d, x, t, u, acc, w1, w2, w5, w6;
      btp_pkg::result_t r;
      t3  = temp_calib[7:0];
      p1  = press_a[47:32];
      p2  = press_a[31:16];
      p3  = press_a[15:8];
      p4  = press_a[7:0];
      p7  = press_b[15:8];
      p8  = press_b[7:0];
      p9  = press_c[31:16];
      p10 = press_c[15:8];
      p11 = press_c[7:0];
      w1 = $signed({112'd0, temp_calib[39:24]});
      w2 = $signed({112'd0, temp_calib[23:8]});
      w5 = $signed({112'd0, press_b[47:32]});
      w6 = $signed({112'd0, press_b[31:16]});
      u  = $signed({104'd0, s.raw_press});
      d  = $signed({104'd0, s.raw_temp}) - (w1 <<< 8);
      x  = ((d * w2) <<< 18) + d * d * wide_t'(t3);
      x  = (x + (wide_t'(1) <<< 31)) >>> 32;
      if (x < -(wide_t'(1) <<< 23)) t = -(wide_t'(1) <<< 23);
      else if (x > (wide_t'(1) <<< 23) - 1) t = (wide_t'(1) <<< 23) - 1;
      else t = x;
      acc = poly_term(w5, 0, 0, 0, 0, -3)
          + poly_term(w6, 0, 0, t, 1, 6)
          + poly_term(wide_t'(p7), 0, 0, t, 2, 8)
          + poly_term(wide_t'(p8), 0, 0, t, 3, 15)
          + poly_term(wide_t'(p1) - 16384, u, 1, 0, 0, 20)
          + poly_term(wide_t'(p2) - 16384, u, 1, t, 1, 29)
          + poly_term(wide_t'(p3), u, 1, t, 2, 32)
          + poly_term(wide_t'(p4), u, 1, t, 3, 37)
          + poly_term(wide_t'(p9), u, 2, 0, 0, 48)
          + poly_term(wide_t'(p10), u, 2, t, 1, 48)
          + poly_term(wide_t'(p11), u, 3, 0, 0, 65);
      acc = (acc + (wide_t'(1) <<< 17)) >>> 18;
      r.temp_q16 = t[23:0];
      if (acc < 0) begin
        r.press_q6 = '0;
        r.press_clamped = 1'b1;
      end else if (acc > 24'hFFFFFF) begin
        r.press_q6 = '1;
        r.press_clamped = 1'b1;
      end else begin
        r.press_q6 = acc[23:0];
        r.press_clamped = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(btp_pkg::result_t got);
      btp_pkg::result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result temp_q16=%0d press_q6=%0d", got.temp_q16, got.press_q6);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.temp_q16 !== exp_r.temp_q16) begin
        $error("temp_q16 expected %0d actual %0d", exp_r.temp_q16, got.temp_q16);
        errors++;
      end
      if (got.press_q6 !== exp_r.press_q6) begin
        $error("press_q6 expected %0d actual %0d", exp_r.press_q6, got.press_q6);
        errors++;
      end
      if (got.press_clamped !== exp_r.press_clamped) begin
        $error("press_clamped expected %0b actual %0b",
               exp_r.press_clamped, got.press_clamped);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  btp_pkg::sample_t              sample;
  logic                          done;
  btp_pkg::result_t              result;
  logic                          cfg_we;
  logic [btp_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [btp_pkg::CFG_W-1:0]     cfg_wdata;

  comp_scoreboard sb = new();

  baro_temp_press_compensation DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_sample(sample);
      if (done) sb.check_result(result);
      if (cfg_we) sb.write_reg(cfg_idx, cfg_wdata);
    end
  end

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 60) n = 0;
    else if (r < 95) n = $urandom_range(3, 1);
    else n = $urandom_range(40, 10);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // without gaps, start stays high until the next call or drain
  task automatic send_sample(logic [23:0] rt, logic [23:0] rp, bit gaps);
    start <= 1'b1;
    sample <= '{raw_temp: rt, raw_press: rp};
    do @(posedge clk); while (busy);
    if (gaps) idle_gap();
  endtask

  // hold off until the pipeline has drained
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [btp_pkg::CFG_IDX_W-1:0] idx,
                           logic [btp_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_calib(logic [47:0] tc, logic [47:0] pa, logic [47:0] pb,
                            logic [47:0] pc);
    write_reg(btp_pkg::REG_TEMP_CALIB, tc);
    write_reg(btp_pkg::REG_PRESS_A, pa);
    write_reg(btp_pkg::REG_PRESS_B, pb);
    write_reg(btp_pkg::REG_PRESS_C, pc);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [23:0] rand_raw();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 24'h000000;
    if (r == 1) return 24'hFFFFFF;
    if (r < 6) return 24'($urandom_range(24'h900000, 24'h500000));
    return 24'($urandom());
  endfunction

  // realistic device-like calibration
  localparam logic [47:0] TYP_TEMP  = {8'h00, 16'd27504, 16'd26435, 8'hFD};
  localparam logic [47:0] TYP_A     = {16'sd18000, 16'sd16600, 8'sd20, 8'sd2};
  localparam logic [47:0] TYP_B     = {16'd25000, 16'd14000, 8'sd3, -8'sd7};
  localparam logic [47:0] TYP_C     = {16'd0, 16'sd500, 8'sd1, -8'sd1};

  initial begin
    rst = 1'b1;
    start = 1'b0;
    sample = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-zero calibration after reset
    send_sample(24'h000000, 24'h000000, 0);
    send_sample(24'hFFFFFF, 24'hFFFFFF, 0);
    drain();

    load_calib(TYP_TEMP, TYP_A, TYP_B, TYP_C);
    // out-of-range index must be ignored
    write_reg(4'd4, 48'hFFFFFFFFFFFF);
    write_reg(4'd15, 48'hFFFFFFFFFFFF);
    send_sample(24'h6B0000, 24'h700000, 0);
    send_sample(24'h000000, 24'h000000, 0);
    send_sample(24'hFFFFFF, 24'hFFFFFF, 0);
    send_sample(24'h000000, 24'hFFFFFF, 0);
    send_sample(24'hFFFFFF, 24'h000000, 0);
    send_sample(24'h800000, 24'h7FFFFF, 0);
    send_sample(24'h555555, 24'hAAAAAA, 0);
    send_sample(24'hAAAAAA, 24'h555555, 0);
    drain();

    // temperature saturation both ways, pressure clamp both ways
    load_calib({8'h00, 16'h0000, 16'hFFFF, 8'h7F}, {16'h7FFF, 16'h7FFF, 8'h7F, 8'h7F},
               {16'hFFFF, 16'hFFFF, 8'h7F, 8'h7F}, {16'h0000, 16'h7FFF, 8'h7F, 8'h7F});
    send_sample(24'hFFFFFF, 24'hFFFFFF, 0);
    send_sample(24'h000001, 24'h000000, 0);
    drain();
    load_calib({8'h00, 16'hFFFF, 16'hFFFF, 8'h80}, {16'h8000, 16'h8000, 8'h80, 8'h80},
               {16'h0000, 16'h0000, 8'h80, 8'h80}, {16'h0000, 16'h8000, 8'h80, 8'h80});
    send_sample(24'h000000, 24'hFFFFFF, 0);
    send_sample(24'hFFFFFF, 24'hFFFFFF, 0);
    send_sample(24'h000000, 24'h000000, 0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: load_calib(TYP_TEMP, TYP_A, TYP_B, TYP_C);
        1: load_calib(rand48(), rand48(), rand48(), rand48());
        2: load_calib({8'h00, 16'd27000 + 16'($urandom_range(1000)),
                       16'($urandom_range(30000, 20000)), 8'($urandom_range(255))},
                      {16'($urandom_range(20000, 14000)), 16'($urandom_range(20000, 12000)),
                       8'($urandom), 8'($urandom)},
                      {16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom)},
                      {16'd0, 16'($urandom_range(2000)), 8'($urandom), 8'($urandom)});
        default: load_calib('1, '1, '1, '1);
      endcase
      if ($urandom_range(1)) write_reg(4'($urandom_range(15, 4)), rand48());
      for (int i = 0; i < 140; i++) send_sample(rand_raw(), rand_raw(), 1);
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (sb.pending.size() != 0)
        $error("%0d expected results never arrived", sb.pending.size());
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
